[rtl/falling_sand_grid_sweep_unit_assert.svh]
// Assertion macros for the falling sand grid sweep unit.
// Expects signals clk and rst in the scope of use.
`ifndef FALLING_SAND_GRID_SWEEP_UNIT_ASSERT_SVH
`define FALLING_SAND_GRID_SWEEP_UNIT_ASSERT_SVH

// same-cycle implication
`define FSGS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsgs assertion failed");

// next-cycle implication
`define FSGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsgs assertion failed");

`endif

[rtl/fsgs_pkg.sv]
// Shared types and constants of the falling sand grid sweep unit.
// No dependencies.
package fsgs_pkg;

  localparam logic [1:0] MAT_BLANK = 2'd0;
  localparam logic [1:0] MAT_SAND  = 2'd1;
  localparam logic [1:0] MAT_WATER = 2'd2;
  localparam logic [1:0] MAT_ROCK  = 2'd3;

  localparam logic [1:0] FUNC_PAINT = 2'd0;
  localparam logic [1:0] FUNC_SWEEP = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [15:0] SEED_DEFAULT = 16'd44257;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] col;
    logic [6:0] row;
    logic [1:0] material;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cell_material;
    logic       is_read_answer;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

[rtl/fsgs_grid_mem.sv]
// Single-port grid memory, 2-bit cells, registered read.
// No dependencies.
module fsgs_grid_mem #(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [1:0]    wdata,
  output logic [1:0]    rdata
);

  logic [1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/fsgs_rng.sv]
// 16-bit Galois LFSR supplying one direction bit per draw.
// Depends on fsgs_pkg.
module fsgs_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [15:0] seed,
  input  logic        step,
  output logic        bit_out
);

  logic [15:0] shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= fsgs_pkg::SEED_DEFAULT;
    end else if (seed_we) begin
      shift <= (seed == 16'd0) ? fsgs_pkg::SEED_DEFAULT : seed;
    end else if (step) begin
      shift <= (shift >> 1) ^ (shift[0] ? fsgs_pkg::LFSR_TAPS : 16'd0);
    end
  end

  assign bit_out = shift[0];

endmodule

[rtl/fsgs_engine.sv]
// Sequencer: clearing pass, paint, read and sweep over the grid memory port.
// Depends on fsgs_pkg.
module fsgs_engine #(
  parameter int GRID_COLUMNS = 256,
  parameter int GRID_ROWS    = 128,
  parameter int COL_W        = 8,
  parameter int ROW_W        = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  fsgs_pkg::in_item_t       item,
  input  logic                     take,
  input  logic                     rnd,
  output logic                     draw,
  output fsgs_pkg::out_item_t      result,
  output fsgs_pkg::eng_stat_t      stat,
  output logic                     mem_en,
  output logic                     mem_we,
  output logic [ROW_W+COL_W-1:0]   mem_addr,
  output logic [1:0]               mem_wdata,
  input  logic [1:0]               mem_rdata
);

  localparam int AW = ROW_W + COL_W;
  localparam logic [COL_W-1:0] X_LAST = COL_W'(GRID_COLUMNS - 1);
  localparam logic [ROW_W-1:0] Y_LAST = ROW_W'(GRID_ROWS - 1);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PAINT = 4'd2;
  localparam logic [3:0] ST_RQ    = 4'd3;
  localparam logic [3:0] ST_RC    = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_DEC   = 4'd6;
  localparam logic [3:0] ST_WR    = 4'd7;
  localparam logic [3:0] ST_NEXT  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  // neighborhood slots, fetched in this order
  localparam logic [2:0] NB_C   = 3'd0;
  localparam logic [2:0] NB_B   = 3'd1;
  localparam logic [2:0] NB_L   = 3'd2;
  localparam logic [2:0] NB_R   = 3'd3;
  localparam logic [2:0] NB_BL  = 3'd4;
  localparam logic [2:0] NB_BR  = 3'd5;
  localparam logic [2:0] NB_CNT = 3'd6;

  localparam logic [1:0] WS_T = 2'd0;
  localparam logic [1:0] WS_S = 2'd1;
  localparam logic [1:0] WS_C = 2'd2;

  logic [3:0]       state;
  logic [AW-1:0]    clr_addr;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;
  logic             left_first;
  logic             in_grid;
  logic [1:0]       paint_val;
  logic [2:0]       k;
  logic             pend;
  logic [2:0]       pk;
  logic [1:0]       nb [0:5];
  logic [1:0]       wstep;
  logic             t_en, s_en, c_en;
  logic [AW-1:0]    t_addr, s_addr;
  logic [1:0]       t_val, s_val, c_val;

  logic [COL_W-1:0] xl, xr;
  logic [ROW_W-1:0] yb;
  logic             hb, lok, rok, f_ok, s2_ok, below_blank;
  logic [1:0]       f_side, f_diag, s2_side, s2_diag;
  logic [AW-1:0]    f_saddr, f_daddr, s2_saddr, s2_daddr, rd_addr;
  logic             d_t_en, d_s_en, d_c_en;
  logic [AW-1:0]    d_t_addr, d_s_addr;
  logic [1:0]       d_t_val, d_s_val, d_c_val;
  logic             last_col;

  assign xl = x - COL_W'(1);
  assign xr = x + COL_W'(1);
  assign yb = y + ROW_W'(1);
  assign hb  = (y != Y_LAST);
  assign lok = (x != '0);
  assign rok = (x != X_LAST);
  assign below_blank = hb && (nb[NB_B] == fsgs_pkg::MAT_BLANK);

  // first and second choice of side, picked by the drawn bit
  assign f_ok     = rnd ? rok : lok;
  assign s2_ok    = rnd ? lok : rok;
  assign f_side   = rnd ? nb[NB_R] : nb[NB_L];
  assign s2_side  = rnd ? nb[NB_L] : nb[NB_R];
  assign f_diag   = rnd ? nb[NB_BR] : nb[NB_BL];
  assign s2_diag  = rnd ? nb[NB_BL] : nb[NB_BR];
  assign f_saddr  = rnd ? {y, xr} : {y, xl};
  assign s2_saddr = rnd ? {y, xl} : {y, xr};
  assign f_daddr  = rnd ? {yb, xr} : {yb, xl};
  assign s2_daddr = rnd ? {yb, xl} : {yb, xr};

  assign draw = (state == ST_DEC) && !below_blank;
  assign last_col = left_first ? (x == X_LAST) : (x == '0);

  always_comb begin
    case (k)
      NB_C:    rd_addr = {y, x};
      NB_B:    rd_addr = {yb, x};
      NB_L:    rd_addr = {y, xl};
      NB_R:    rd_addr = {y, xr};
      NB_BL:   rd_addr = {yb, xl};
      NB_BR:   rd_addr = {yb, xr};
      default: rd_addr = {y, x};
    endcase
  end

  // move decision for the cell under visit
  always_comb begin
    d_t_en = 1'b0; d_t_addr = {yb, x}; d_t_val = fsgs_pkg::MAT_BLANK;
    d_s_en = 1'b0; d_s_addr = f_saddr; d_s_val = fsgs_pkg::MAT_WATER;
    d_c_en = 1'b0; d_c_val = fsgs_pkg::MAT_BLANK;
    if (below_blank) begin
      d_t_en  = 1'b1;
      d_t_val = nb[NB_C];
      d_c_en  = 1'b1;
    end else if (nb[NB_C] == fsgs_pkg::MAT_SAND) begin
      if (hb && nb[NB_B] == fsgs_pkg::MAT_WATER) begin
        // sand sinks, displaced water goes sideways or takes the sand's place
        d_t_en  = 1'b1;
        d_t_val = fsgs_pkg::MAT_SAND;
        d_c_en  = 1'b1;
        if (f_ok && f_side == fsgs_pkg::MAT_BLANK) begin
          d_s_en = 1'b1;
        end else if (s2_ok && s2_side == fsgs_pkg::MAT_BLANK) begin
          d_s_en   = 1'b1;
          d_s_addr = s2_saddr;
        end else begin
          d_c_val = fsgs_pkg::MAT_WATER;
        end
      end else if (hb && f_ok && (f_diag == fsgs_pkg::MAT_BLANK ||
                   f_diag == fsgs_pkg::MAT_WATER) && f_side != fsgs_pkg::MAT_ROCK) begin
        d_t_en = 1'b1; d_t_addr = f_daddr; d_t_val = fsgs_pkg::MAT_SAND;
        d_c_en = 1'b1; d_c_val = f_diag;
      end else if (hb && s2_ok && (s2_diag == fsgs_pkg::MAT_BLANK ||
                   s2_diag == fsgs_pkg::MAT_WATER) && s2_side != fsgs_pkg::MAT_ROCK) begin
        d_t_en = 1'b1; d_t_addr = s2_daddr; d_t_val = fsgs_pkg::MAT_SAND;
        d_c_en = 1'b1; d_c_val = s2_diag;
      end
    end else begin
      if (hb && f_ok && f_diag == fsgs_pkg::MAT_BLANK && f_side != fsgs_pkg::MAT_ROCK) begin
        d_t_en = 1'b1; d_t_addr = f_daddr; d_t_val = fsgs_pkg::MAT_WATER;
        d_c_en = 1'b1;
      end else if (hb && s2_ok && s2_diag == fsgs_pkg::MAT_BLANK &&
                   s2_side != fsgs_pkg::MAT_ROCK) begin
        d_t_en = 1'b1; d_t_addr = s2_daddr; d_t_val = fsgs_pkg::MAT_WATER;
        d_c_en = 1'b1;
      end else if (f_ok && f_side == fsgs_pkg::MAT_BLANK) begin
        d_s_en = 1'b1;
        d_c_en = 1'b1;
      end else if (s2_ok && s2_side == fsgs_pkg::MAT_BLANK) begin
        d_s_en = 1'b1; d_s_addr = s2_saddr;
        d_c_en = 1'b1;
      end
    end
  end

  // memory port
  always_comb begin
    mem_en = 1'b0; mem_we = 1'b0; mem_addr = {y, x}; mem_wdata = paint_val;
    case (state)
      ST_CLR: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = clr_addr;
        mem_wdata = fsgs_pkg::MAT_BLANK;
      end
      ST_PAINT: begin
        mem_en = in_grid; mem_we = in_grid;
      end
      ST_RQ: begin
        mem_en = 1'b1;
      end
      ST_RD: begin
        mem_en = (k < NB_CNT); mem_addr = rd_addr;
      end
      ST_WR: begin
        case (wstep)
          WS_T: begin
            mem_en = t_en; mem_we = t_en; mem_addr = t_addr; mem_wdata = t_val;
          end
          WS_S: begin
            mem_en = s_en; mem_we = s_en; mem_addr = s_addr; mem_wdata = s_val;
          end
          default: begin
            mem_en = c_en; mem_we = c_en; mem_wdata = c_val;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_addr   <= '0;
      left_first <= 1'b1;
      k          <= '0;
      pend       <= 1'b0;
      wstep      <= WS_T;
    end else begin
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            x <= COL_W'(item.col);
            y <= ROW_W'(item.row);
            in_grid <= (32'(item.col) < GRID_COLUMNS) && (32'(item.row) < GRID_ROWS);
            paint_val <= (item.material == fsgs_pkg::MAT_SAND ||
                          item.material == fsgs_pkg::MAT_WATER) ? item.material
                                                               : fsgs_pkg::MAT_ROCK;
            result <= '0;
            case (item.func)
              fsgs_pkg::FUNC_PAINT: state <= ST_PAINT;
              fsgs_pkg::FUNC_READ:  state <= ST_RQ;
              fsgs_pkg::FUNC_SWEEP: begin
                left_first <= !left_first;
                x     <= left_first ? X_LAST : '0;
                y     <= Y_LAST;
                k     <= NB_C;
                pend  <= 1'b0;
                state <= ST_RD;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_PAINT: state <= ST_DONE;
        ST_RQ:    state <= ST_RC;
        ST_RC: begin
          result.cell_material  <= in_grid ? mem_rdata : fsgs_pkg::MAT_BLANK;
          result.is_read_answer <= 1'b1;
          state <= ST_DONE;
        end
        ST_RD: begin
          if (pend) begin
            nb[pk] <= mem_rdata;
          end
          pend <= (k < NB_CNT);
          pk   <= k;
          if (k < NB_CNT) begin
            k <= k + 3'd1;
          end
          // blank and rock cells never move: skip the rest of the fetch
          if (pend && pk == NB_C && mem_rdata != fsgs_pkg::MAT_SAND &&
              mem_rdata != fsgs_pkg::MAT_WATER) begin
            state <= ST_NEXT;
          end else if (pend && pk == NB_BR) begin
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          t_en <= d_t_en; t_addr <= d_t_addr; t_val <= d_t_val;
          s_en <= d_s_en; s_addr <= d_s_addr; s_val <= d_s_val;
          c_en <= d_c_en; c_val <= d_c_val;
          wstep <= WS_T;
          state <= ST_WR;
        end
        ST_WR: begin
          if (wstep == WS_C) begin
            state <= ST_NEXT;
          end else begin
            wstep <= wstep + 2'd1;
          end
        end
        ST_NEXT: begin
          k    <= NB_C;
          pend <= 1'b0;
          if (last_col) begin
            if (y == '0) begin
              state <= ST_DONE;
            end else begin
              y     <= y - ROW_W'(1);
              x     <= left_first ? '0 : X_LAST;
              state <= ST_RD;
            end
          end else begin
            x     <= left_first ? xr : xl;
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

endmodule

[rtl/falling_sand_grid_sweep_unit.sv]
// Falling sand grid sweep unit. One item at a time; every item gives one result
// beat. After reset a clearing pass blanks the grid memory, 2^(clog2(GRID_ROWS)+
// clog2(GRID_COLUMNS)) addresses (32768 at the defaults), with in_stall high. Paint
// writes the cell, read fetches it, other codes go to done, where each result waits to
// be handed over. A sweep runs on the single-port grid memory: a blank or rock cell is
// left after its centre read, a sand or water cell takes six neighborhood reads, a
// decision and three write slots. The next item is taken while a result beat still
// waits in the output register. Write rng_seed only while idle. Depends on fsgs_pkg,
// fsgs_grid_mem, fsgs_rng, fsgs_engine and the assertion header.
`include "falling_sand_grid_sweep_unit_assert.svh"

module falling_sand_grid_sweep_unit #(
  parameter int GRID_COLUMNS = 256,
  parameter int GRID_ROWS    = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsgs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fsgs_pkg::out_item_t out_data,
  input  logic                rng_seed_we,
  input  logic [15:0]         rng_seed
);

  localparam int COL_W = $clog2(GRID_COLUMNS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int AW    = COL_W + ROW_W;

  fsgs_pkg::eng_stat_t eng_stat;
  fsgs_pkg::out_item_t eng_result;
  logic                start, take, rnd, draw;
  logic                mem_en, mem_we;
  logic [AW-1:0]       mem_addr;
  logic [1:0]          mem_wdata, mem_rdata;

  assign in_stall = !eng_stat.idle;
  assign start    = in_valid && eng_stat.idle;
  assign take     = eng_stat.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= eng_result;
    end
  end

  fsgs_grid_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fsgs_rng u_rng (
    .clk     (clk),
    .rst     (rst),
    .seed_we (rng_seed_we),
    .seed    (rng_seed),
    .step    (draw),
    .bit_out (rnd)
  );

  fsgs_engine #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .COL_W        (COL_W),
    .ROW_W        (ROW_W)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (in_data),
    .take      (take),
    .rnd       (rnd),
    .draw      (draw),
    .result    (eng_result),
    .stat      (eng_stat),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // accepted item always starts work
  `FSGS_ASSERT_NEXT(a_start_busy, in_valid && !in_stall, !eng_stat.idle)
  // output register is loaded only from a finished item
  `FSGS_ASSERT_SAME(a_load_done, $rose(out_valid), $past(eng_stat.done))
  // finished result is held while the output slot is blocked
  `FSGS_ASSERT_NEXT(a_hold_done, eng_stat.done && out_valid && out_stall, eng_stat.done)

endmodule

[tb/sv/falling_sand_grid_sweep_unit_test.sv]
// Testbench for falling_sand_grid_sweep_unit: directed and random paint/read/sweep beats,
// checked against an in-bench grid predictor. Depends on fsgs_pkg and the RTL.
`timescale 1ns / 1ps

module falling_sand_grid_sweep_unit_test;

  localparam int COLS  = 256;
  localparam int ROWS  = 128;
  localparam int LIMIT = 40_000_000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  fsgs_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  fsgs_pkg::out_item_t out_data;
  logic        rng_seed_we = 0;
  logic [15:0] rng_seed = '0;

  falling_sand_grid_sweep_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .rng_seed_we(rng_seed_we), .rng_seed(rng_seed)
  );

  always #5 clk = ~clk;

  // grid predictor state
  logic [1:0]  grid_model [0:COLS*ROWS-1];
  logic        scan_lr;
  logic [15:0] dir_shift;

  fsgs_pkg::in_item_t  pending_items [$];
  fsgs_pkg::out_item_t cell_answers  [$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 0;
  bit  in_fire = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic logic [1:0] cell_at(int x, int y);
    return grid_model[y*COLS + x];
  endfunction

  function automatic void put(int x, int y, logic [1:0] v);
    grid_model[y*COLS + x] = v;
  endfunction

  function automatic bit draw_dir();
    bit b;
    b = dir_shift[0];
    dir_shift = dir_shift >> 1;
    if (b) dir_shift = dir_shift ^ fsgs_pkg::LFSR_TAPS;
    return b;
  endfunction

  function automatic int side(bit right, int k, int x);
    return ((right == 1'b1) == (k == 0)) ? x + 1 : x - 1;
  endfunction

  function automatic void sand_step(int x, int y);
    bit has_below;
    bit right;
    int d;
    logic [1:0] t;
    has_below = (y + 1) < ROWS;
    if (has_below) begin
      t = cell_at(x, y + 1);
      if (t == fsgs_pkg::MAT_BLANK) begin
        put(x, y + 1, fsgs_pkg::MAT_SAND);
        put(x, y, fsgs_pkg::MAT_BLANK);
        return;
      end
      if (t == fsgs_pkg::MAT_WATER) begin
        put(x, y + 1, fsgs_pkg::MAT_SAND);
        right = draw_dir();
        for (int k = 0; k < 2; k++) begin
          d = side(right, k, x);
          if (d >= 0 && d < COLS && cell_at(d, y) == fsgs_pkg::MAT_BLANK) begin
            put(d, y, fsgs_pkg::MAT_WATER);
            put(x, y, fsgs_pkg::MAT_BLANK);
            return;
          end
        end
        put(x, y, fsgs_pkg::MAT_WATER);
        return;
      end
    end
    right = draw_dir();
    for (int k = 0; k < 2; k++) begin
      d = side(right, k, x);
      if (has_below && d >= 0 && d < COLS) begin
        t = cell_at(d, y + 1);
        if ((t == fsgs_pkg::MAT_BLANK || t == fsgs_pkg::MAT_WATER) &&
            cell_at(d, y) != fsgs_pkg::MAT_ROCK) begin
          put(d, y + 1, fsgs_pkg::MAT_SAND);
          put(x, y, t);
          return;
        end
      end
    end
  endfunction

  function automatic void water_step(int x, int y);
    bit has_below;
    bit right;
    int d;
    has_below = (y + 1) < ROWS;
    if (has_below && cell_at(x, y + 1) == fsgs_pkg::MAT_BLANK) begin
      put(x, y + 1, fsgs_pkg::MAT_WATER);
      put(x, y, fsgs_pkg::MAT_BLANK);
      return;
    end
    right = draw_dir();
    for (int k = 0; k < 2; k++) begin
      d = side(right, k, x);
      if (has_below && d >= 0 && d < COLS && cell_at(d, y + 1) == fsgs_pkg::MAT_BLANK &&
          cell_at(d, y) != fsgs_pkg::MAT_ROCK) begin
        put(d, y + 1, fsgs_pkg::MAT_WATER);
        put(x, y, fsgs_pkg::MAT_BLANK);
        return;
      end
    end
    for (int k = 0; k < 2; k++) begin
      d = side(right, k, x);
      if (d >= 0 && d < COLS && cell_at(d, y) == fsgs_pkg::MAT_BLANK) begin
        put(d, y, fsgs_pkg::MAT_WATER);
        put(x, y, fsgs_pkg::MAT_BLANK);
        return;
      end
    end
  endfunction

  function automatic void sweep_model();
    int x;
    logic [1:0] m;
    scan_lr = ~scan_lr;
    for (int y = ROWS - 1; y >= 0; y--) begin
      for (int i = 0; i < COLS; i++) begin
        x = scan_lr ? i : COLS - 1 - i;
        m = cell_at(x, y);
        if (m == fsgs_pkg::MAT_SAND) sand_step(x, y);
        else if (m == fsgs_pkg::MAT_WATER) water_step(x, y);
      end
    end
  endfunction

  function automatic fsgs_pkg::out_item_t apply_item(fsgs_pkg::in_item_t it);
    fsgs_pkg::out_item_t r;
    bit in_grid;
    r = '0;
    in_grid = it.col < COLS && it.row < ROWS;
    case (it.func)
      fsgs_pkg::FUNC_PAINT: begin
        if (in_grid)
          put(it.col, it.row, (it.material == fsgs_pkg::MAT_SAND ||
              it.material == fsgs_pkg::MAT_WATER) ? it.material : fsgs_pkg::MAT_ROCK);
      end
      fsgs_pkg::FUNC_SWEEP: sweep_model();
      fsgs_pkg::FUNC_READ: begin
        r.cell_material = in_grid ? cell_at(it.col, it.row) : fsgs_pkg::MAT_BLANK;
        r.is_read_answer = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic add(int f, int c, int r, int m);
    fsgs_pkg::in_item_t it;
    it.func = 2'(f);
    it.col = 8'(c);
    it.row = 7'(r);
    it.material = 2'(m);
    pending_items.push_back(it);
  endtask

  // idle point: sender drained and every result back
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && cell_answers.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_seed(logic [15:0] v);
    @(negedge clk);
    rng_seed_we <= 1'b1;
    rng_seed <= v;
    dir_shift = (v == 16'd0) ? fsgs_pkg::SEED_DEFAULT : v;
    @(negedge clk);
    rng_seed_we <= 1'b0;
  endtask

  // paints and reads around a random spot, two sweeps at fixed points, some random items
  task automatic random_phase(int count);
    int bc, br;
    bc = $urandom_range(1, COLS - 2);
    br = $urandom_range(ROWS - 6, ROWS - 1);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3 || i == count - 4)
        add(fsgs_pkg::FUNC_SWEEP, $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 9) == 0)
        add($urandom_range(0, 3), $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 1) == 0)
        add(fsgs_pkg::FUNC_PAINT, bc + $urandom_range(0, 4) - 2, br - $urandom_range(0, 4),
            $urandom_range(0, 3));
      else
        add(fsgs_pkg::FUNC_READ, bc + $urandom_range(0, 4) - 2,
            br - $urandom_range(0, 4) + 1 > 127 ? 127 : br - $urandom_range(0, 4) + 1,
            $urandom);
    end
  endtask

  // input acceptance and prediction
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_fire = in_valid && !in_stall && !rst;
    if (in_fire) cell_answers.push_back(apply_item(in_data));
    if (cycles > LIMIT) begin
      $display("FAIL falling_sand_grid_sweep_unit");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    fsgs_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cell_answers.size() == 0) begin
        report_mismatch("unexpected beat", out_data, 0);
      end else begin
        want = cell_answers.pop_front();
        if (out_data.cell_material !== want.cell_material)
          report_mismatch("cell_material", out_data.cell_material, want.cell_material);
        if (out_data.is_read_answer !== want.is_read_answer)
          report_mismatch("is_read_answer", out_data.is_read_answer, want.is_read_answer);
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold stalled beat
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      send_gap <= $urandom_range(0, 3);
      in_valid <= 1'b0;
    end else begin
      in_data <= pending_items.pop_front();
      in_valid <= 1'b1;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      recv_gap <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    for (int i = 0; i < COLS * ROWS; i++) grid_model[i] = fsgs_pkg::MAT_BLANK;
    scan_lr = 1'b1;
    dir_shift = fsgs_pkg::SEED_DEFAULT;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // clearing pass holds in_stall high
    do @(negedge clk); while (in_stall);
    load_seed(16'd0);

    // directed: field extremes, every func, rock for material zero, sand into water
    add(fsgs_pkg::FUNC_PAINT, 0, 0, fsgs_pkg::MAT_SAND);
    add(fsgs_pkg::FUNC_PAINT, 255, 127, fsgs_pkg::MAT_WATER);
    add(fsgs_pkg::FUNC_PAINT, 128, 64, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_PAINT, 20, 127, fsgs_pkg::MAT_ROCK);
    add(fsgs_pkg::FUNC_PAINT, 20, 126, fsgs_pkg::MAT_WATER);
    add(fsgs_pkg::FUNC_PAINT, 20, 125, fsgs_pkg::MAT_SAND);
    add(fsgs_pkg::FUNC_PAINT, 21, 125, fsgs_pkg::MAT_WATER);
    add(fsgs_pkg::FUNC_PAINT, 19, 126, fsgs_pkg::MAT_ROCK);
    add(FUNC_SPARE, 255, 127, fsgs_pkg::MAT_ROCK);
    add(fsgs_pkg::FUNC_READ, 0, 0, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_READ, 255, 127, fsgs_pkg::MAT_ROCK);
    add(fsgs_pkg::FUNC_READ, 128, 64, fsgs_pkg::MAT_SAND);
    add(fsgs_pkg::FUNC_SWEEP, 0, 0, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_READ, 0, 1, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_READ, 20, 126, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_READ, 20, 125, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_READ, 21, 126, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_SWEEP, 255, 127, fsgs_pkg::MAT_ROCK);
    add(fsgs_pkg::FUNC_READ, 0, 2, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_READ, 21, 125, fsgs_pkg::MAT_BLANK);
    add(fsgs_pkg::FUNC_READ, 254, 127, fsgs_pkg::MAT_BLANK);
    drain();

    load_seed(16'd1);
    random_phase(34);
    drain();
    load_seed(16'hFFFF);
    random_phase(33);
    drain();
    load_seed(16'($urandom_range(1, 65535)));
    calm = 1;
    random_phase(33);
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && cell_answers.size() == 0)
      $display("PASS falling_sand_grid_sweep_unit");
    else
      $display("FAIL falling_sand_grid_sweep_unit");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/fsgs_pkg.sv
rtl/fsgs_grid_mem.sv
rtl/fsgs_rng.sv
rtl/fsgs_engine.sv
rtl/falling_sand_grid_sweep_unit.sv
tb/sv/falling_sand_grid_sweep_unit_test.sv
